// ===== hdl/pntg_pkg.sv =====
// Shared constants and the gamma threshold table of the PBR Neutral tone mapper.
package pntg_pkg;

  localparam int IN_W = 25;
  localparam int OUT_W = 8;
  localparam int A30_W = 30;
  localparam int THR_W = 31;

  function automatic logic [255:0][THR_W-1:0] gamma_thr_f();
    logic [255:0][THR_W-1:0] tab;
    longint unsigned q;
    longint unsigned p;
    longint unsigned t;
    longint unsigned cand;
    longint unsigned pw;
    for (int k = 0; k < 256; k++) begin
      q = (longint'(k) << 30) / 255;
      p = q;
      for (int i = 0; i < 10; i++) begin
        p = (p * q) >> 30;
      end
      t = 0;
      for (int b = 30; b >= 0; b--) begin
        cand = t | (64'd1 << b);
        pw = cand;
        for (int j = 0; j < 4; j++) begin
          pw = (pw * cand) >> 30;
        end
        if (cand <= (64'd1 << 30) && pw <= p) begin
          t = cand;
        end
      end
      tab[k] = THR_W'(t);
    end
    return tab;
  endfunction

  localparam logic [255:0][THR_W-1:0] GAMMA_THR = gamma_thr_f();

endpackage

// ===== hdl/pntg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband payload.
module pntg_div #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] rem_in   [QW];
  logic [DW-1:0] den_in   [QW];
  logic [QW-1:0] quo_in   [QW];
  logic [SW-1:0] side_in  [QW];
  logic          vld_in   [QW];
  logic [RW-1:0] dsh      [QW];
  logic          ge       [QW];
  logic [QW-1:0] quo_nxt  [QW];
  logic [RW-1:0] rem_r    [QW];
  logic [DW-1:0] den_r    [QW];
  logic [QW-1:0] quo_r    [QW];
  logic [SW-1:0] side_r   [QW];
  logic          vld_r    [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign rem_in[i]  = RW'(in_num);
      assign den_in[i]  = in_den;
      assign quo_in[i]  = '0;
      assign side_in[i] = in_side;
      assign vld_in[i]  = in_valid;
    end else begin : g_next
      assign rem_in[i]  = rem_r[i-1];
      assign den_in[i]  = den_r[i-1];
      assign quo_in[i]  = quo_r[i-1];
      assign side_in[i] = side_r[i-1];
      assign vld_in[i]  = vld_r[i-1];
    end

    assign dsh[i] = RW'(den_in[i]) << (QW - 1 - i);
    assign ge[i]  = rem_in[i] >= dsh[i];

    always_comb begin
      quo_nxt[i] = quo_in[i];
      quo_nxt[i][QW-1-i] = ge[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge[i] ? rem_in[i] - dsh[i] : rem_in[i];
        den_r[i]  <= den_in[i];
        quo_r[i]  <= quo_nxt[i];
        side_r[i] <= side_in[i];
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ===== hdl/pntg_gamma.sv =====
// Eight-stage binary search of the gamma threshold table for one channel.
module pntg_gamma (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [pntg_pkg::A30_W-1:0] in_a30,
  input  logic                       in_sat,
  output logic                       out_valid,
  output logic [pntg_pkg::OUT_W-1:0] out_byte
);

  localparam int NS = pntg_pkg::OUT_W;

  logic [pntg_pkg::A30_W-1:0] a_in  [NS];
  logic [NS-1:0]              k_in  [NS];
  logic                       v_in  [NS];
  logic [NS-1:0]              cand  [NS];
  logic                       take  [NS];
  logic [pntg_pkg::A30_W-1:0] a_r   [NS];
  logic [NS-1:0]              k_r   [NS];
  logic                       v_r   [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign a_in[i] = in_a30;
      assign k_in[i] = in_sat ? {NS{1'b1}} : '0;
      assign v_in[i] = in_valid;
    end else begin : g_next
      assign a_in[i] = a_r[i-1];
      assign k_in[i] = k_r[i-1];
      assign v_in[i] = v_r[i-1];
    end

    assign cand[i] = k_in[i] | NS'(1 << (NS - 1 - i));
    assign take[i] = pntg_pkg::GAMMA_THR[cand[i]] <= {1'b0, a_in[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i] <= a_in[i];
        k_r[i] <= take[i] ? cand[i] : k_in[i];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_byte  = k_r[NS-1];

endmodule

// ===== hdl/pbr_neutral_tonemap_gamma8_top.sv =====
// Top level of the PBR Neutral tone mapper with 8-bit gamma output.
// One pixel enters and one byte triple leaves per clock while the output is not stalled; the
// block keeps no state between pixels. The pipeline contains the bit-serial divider pipelines
// for the peak compression, the desaturation weight and the channel rescale, a four-stage
// reciprocal multiplication for the division by twenty, and an eight-stage gamma table
// search. The whole pipeline holds while a finished result waits to be taken.
module pbr_neutral_tonemap_gamma8_top #(
  parameter int FRAC_BITS = 16,
  parameter int GAMMA_TABLE_ADDR_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pntg_pkg::IN_W-1:0]  in_hdr_red,
  input  logic signed [pntg_pkg::IN_W-1:0]  in_hdr_green,
  input  logic signed [pntg_pkg::IN_W-1:0]  in_hdr_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pntg_pkg::OUT_W-1:0]        out_red,
  output logic [pntg_pkg::OUT_W-1:0]        out_green,
  output logic [pntg_pkg::OUT_W-1:0]        out_blue
);

  localparam int F    = FRAC_BITS;
  localparam int IW   = pntg_pkg::IN_W;
  localparam int AW   = pntg_pkg::A30_W;
  localparam int SQAW = 2 * IW;
  localparam int T25W = SQAW + 5;
  localparam int CW   = (((51 - F) > 25) ? (51 - F) : 25) + 2;
  localparam int NPW  = F + 1;
  localparam int NW1  = (((2 * F) > CW) ? 2 * F : CW) + 1;
  localparam int EW3  = CW + 2;
  localparam int D2W  = CW + 3;
  localparam int NW3  = (((2 * F + 1) > D2W) ? 2 * F + 1 : D2W) + 1;
  localparam int CL   = CW / 2;
  localparam int CH   = CW - CL;
  localparam int PW   = CW + NPW;
  localparam int GMW  = 2 * NPW;
  localparam int MXW  = F + 2;
  localparam int QS   = CW + 3;
  localparam int MW   = CW + 1;
  localparam int NL   = CW / 2;
  localparam int NH   = CW - NL;
  localparam int ML   = MW / 2;
  localparam int MH   = MW - ML;
  localparam int PRW  = CW + MW;

  localparam longint ONE_L = 64'sd1 << F;
  localparam longint ONE2  = ONE_L * ONE_L;
  localparam longint T08   = (2 * ONE_L + 12) / 25;
  localparam longint T04   = (ONE_L + 12) / 25;
  localparam longint T76   = (19 * ONE_L + 12) / 25;
  localparam longint T52   = (13 * ONE_L + 12) / 25;
  localparam longint D2    = ((64'sd36 << (2 * F)) + 312) / 625;
  localparam longint M5    = ((64'sd1 << QS) + 4) / 5;

  localparam logic signed [CW-1:0] T08_C = CW'(T08);
  localparam logic signed [CW-1:0] T04_C = CW'(T04);
  localparam logic [CW-1:0]        T76_C = CW'(T76);
  localparam logic [CW-1:0]        T52_C = CW'(T52);
  localparam logic [CW-1:0]        ONE_C = CW'(ONE_L);
  localparam logic [MW-1:0]        M5_C  = MW'(M5);
  localparam logic [ML-1:0]        M5_L  = M5_C[ML-1:0];
  localparam logic [MH-1:0]        M5_H  = M5_C[MW-1:ML];
  localparam logic [AW-1:0]        AMASK =
    ~((AW'(1) << (AW - GAMMA_TABLE_ADDR_BITS)) - AW'(1));

  typedef struct packed {
    logic          comp;
    logic [CW-1:0] peak;
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
    logic [CW-1:0] c2;
  } sb1_t;

  typedef struct packed {
    logic           comp;
    logic [CW-1:0]  peak;
    logic [CW-1:0]  c0;
    logic [CW-1:0]  c1;
    logic [CW-1:0]  c2;
    logic [NPW-1:0] np;
  } sb2_t;

  typedef struct packed {
    logic           comp;
    logic [NPW-1:0] np;
    logic [NPW-1:0] g;
    logic [CW-1:0]  c0;
  } sba_t;

  logic en;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Toe: minimum channel and its magnitude.
  logic signed [IW-1:0] in_ch [3];
  logic signed [IW-1:0] x_nxt;
  logic [IW-1:0]        ax_nxt;
  logic                 s1_v_r;
  logic signed [IW-1:0] s1_ch_r [3];
  logic signed [IW-1:0] s1_x_r;
  logic [IW-1:0]        s1_ax_r;

  assign in_ch[0] = in_hdr_red;
  assign in_ch[1] = in_hdr_green;
  assign in_ch[2] = in_hdr_blue;

  always_comb begin
    x_nxt = in_ch[0];
    if (in_ch[1] < x_nxt) begin
      x_nxt = in_ch[1];
    end
    if (in_ch[2] < x_nxt) begin
      x_nxt = in_ch[2];
    end
    ax_nxt = x_nxt[IW-1] ? IW'(-x_nxt) : IW'(x_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ch_r <= in_ch;
      s1_x_r  <= x_nxt;
      s1_ax_r <= ax_nxt;
    end
  end

  logic                 s2_v_r;
  logic signed [IW-1:0] s2_ch_r [3];
  logic signed [IW-1:0] s2_x_r;
  logic [SQAW-1:0]      s2_sqa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ch_r  <= s1_ch_r;
      s2_x_r   <= s1_x_r;
      s2_sqa_r <= SQAW'(s1_ax_r) * SQAW'(s1_ax_r);
    end
  end

  // Offset and shifted channels.
  logic [T25W-1:0]      t25;
  logic [CW-1:0]        sq;
  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] off;
  logic signed [CW-1:0] che [3];
  logic [CW-1:0]        c_nxt [3];
  logic                 s3_v_r;
  logic [CW-1:0]        s3_c_r [3];

  always_comb begin
    t25 = (T25W'(s2_sqa_r) << 4) + (T25W'(s2_sqa_r) << 3) + T25W'(s2_sqa_r);
    sq  = CW'(t25 >> (F + 2));
    xe  = CW'(s2_x_r);
    if (xe < T08_C) begin
      off = xe - $signed(sq);
    end else begin
      off = T04_C;
    end
    for (int i = 0; i < 3; i++) begin
      che[i]   = CW'(s2_ch_r[i]);
      c_nxt[i] = CW'(che[i] - off);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c_r <= c_nxt;
    end
  end

  // Peak and knee test.
  logic [CW-1:0] peak_nxt;
  logic          s4_v_r;
  sb1_t          s4_sb_r;

  always_comb begin
    peak_nxt = s3_c_r[0];
    if (s3_c_r[1] > peak_nxt) begin
      peak_nxt = s3_c_r[1];
    end
    if (s3_c_r[2] > peak_nxt) begin
      peak_nxt = s3_c_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sb_r.comp <= peak_nxt >= T76_C;
      s4_sb_r.peak <= peak_nxt;
      s4_sb_r.c0   <= s3_c_r[0];
      s4_sb_r.c1   <= s3_c_r[1];
      s4_sb_r.c2   <= s3_c_r[2];
    end
  end

  // Compressed peak.
  logic [CW-1:0]          den1;
  logic [NW1-1:0]         num1;
  logic                   d1_v;
  logic [F-1:0]           d1_q;
  logic [$bits(sb1_t)-1:0] d1_side;
  sb1_t                   d1_sb;

  assign den1 = s4_sb_r.peak - T52_C;
  assign num1 = NW1'(D2) + NW1'(den1 >> 1);

  pntg_div #(
    .NW(NW1), .DW(CW), .QW(F), .SW($bits(sb1_t))
  ) u_div_peak (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s4_v_r), .in_num(num1), .in_den(den1), .in_side(s4_sb_r),
    .out_valid(d1_v), .out_quo(d1_q), .out_side(d1_side)
  );

  assign d1_sb = sb1_t'(d1_side);

  logic [NPW-1:0] np_nxt;
  logic [CW-1:0]  e_nxt;
  logic           s5_v_r;
  logic [CW-1:0]  s5_e_r;
  sb2_t           s5_sb_r;

  always_comb begin
    np_nxt = NPW'(ONE_L) - NPW'(d1_q);
    e_nxt  = (d1_sb.peak > CW'(np_nxt)) ? d1_sb.peak - CW'(np_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_e_r       <= e_nxt;
      s5_sb_r.comp <= d1_sb.comp;
      s5_sb_r.peak <= d1_sb.peak;
      s5_sb_r.c0   <= d1_sb.c0;
      s5_sb_r.c1   <= d1_sb.c1;
      s5_sb_r.c2   <= d1_sb.c2;
      s5_sb_r.np   <= np_nxt;
    end
  end

  // Desaturation denominator: one plus three twentieths of the peak excess.
  // Three quarters of the excess is divided by five through a reciprocal multiplication.
  logic [EW3-1:0]          num20;
  logic                    q1_v_r;
  logic [CW-1:0]           q1_n_r;
  sb2_t                    q1_sb_r;
  logic                    q2_v_r;
  logic [NL+ML-1:0]        q2_ll_r;
  logic [NL+MH-1:0]        q2_lh_r;
  logic [NH+ML-1:0]        q2_hl_r;
  logic [NH+MH-1:0]        q2_hh_r;
  sb2_t                    q2_sb_r;
  logic                    q3_v_r;
  logic [NL+MW-1:0]        q3_lo_r;
  logic [NH+MW-1:0]        q3_hi_r;
  sb2_t                    q3_sb_r;
  logic [PRW-1:0]          prod5;
  logic                    q4_v_r;
  logic [CW-1:0]           q4_q_r;
  sb2_t                    q4_sb_r;
  logic                    s6_v_r;
  logic [D2W-1:0]          s6_den2_r;
  logic [$bits(sb2_t)-1:0] s6_sb_r;

  assign num20 = (EW3'(s5_e_r) << 1) + EW3'(s5_e_r);
  assign prod5 = (PRW'(q3_hi_r) << NL) + PRW'(q3_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
      q2_v_r <= 1'b0;
      q3_v_r <= 1'b0;
      q4_v_r <= 1'b0;
    end else if (en) begin
      q1_v_r <= s5_v_r;
      q2_v_r <= q1_v_r;
      q3_v_r <= q2_v_r;
      q4_v_r <= q3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_n_r  <= CW'(num20 >> 2);
      q1_sb_r <= s5_sb_r;
      q2_ll_r <= (NL + ML)'(q1_n_r[NL-1:0]) * (NL + ML)'(M5_L);
      q2_lh_r <= (NL + MH)'(q1_n_r[NL-1:0]) * (NL + MH)'(M5_H);
      q2_hl_r <= (NH + ML)'(q1_n_r[CW-1:NL]) * (NH + ML)'(M5_L);
      q2_hh_r <= (NH + MH)'(q1_n_r[CW-1:NL]) * (NH + MH)'(M5_H);
      q2_sb_r <= q1_sb_r;
      q3_lo_r <= ((NL + MW)'(q2_lh_r) << ML) + (NL + MW)'(q2_ll_r);
      q3_hi_r <= ((NH + MW)'(q2_hh_r) << ML) + (NH + MW)'(q2_hl_r);
      q3_sb_r <= q2_sb_r;
      q4_q_r  <= CW'(prod5 >> QS);
      q4_sb_r <= q3_sb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= q4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_den2_r <= D2W'(ONE_L) + D2W'(q4_q_r);
      s6_sb_r   <= q4_sb_r;
    end
  end

  // Desaturation weight.
  logic [NW3-1:0]          num3;
  logic                    dg_v;
  logic [NPW-1:0]          dg_q;
  logic [$bits(sb2_t)-1:0] dg_side;
  sb2_t                    dg_sb;

  assign num3 = NW3'(ONE2) + NW3'(s6_den2_r >> 1);

  pntg_div #(
    .NW(NW3), .DW(D2W), .QW(NPW), .SW($bits(sb2_t))
  ) u_div_weight (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s6_v_r), .in_num(num3), .in_den(s6_den2_r), .in_side(s6_sb_r),
    .out_valid(dg_v), .out_quo(dg_q), .out_side(dg_side)
  );

  assign dg_sb = sb2_t'(dg_side);

  // Channel times compressed peak, in two partial products.
  logic [CW-1:0]      dg_c [3];
  logic               s7_v_r;
  logic [NPW-1:0]     s7_g_r;
  logic [CL+NPW-1:0]  s7_plo_r [3];
  logic [CH+NPW-1:0]  s7_phi_r [3];
  sb2_t               s7_sb_r;

  assign dg_c[0] = dg_sb.c0;
  assign dg_c[1] = dg_sb.c1;
  assign dg_c[2] = dg_sb.c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= dg_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_g_r  <= NPW'(ONE_L) - dg_q;
      s7_sb_r <= dg_sb;
      for (int i = 0; i < 3; i++) begin
        s7_plo_r[i] <= (CL + NPW)'(dg_c[i][CL-1:0]) * (CL + NPW)'(dg_sb.np);
        s7_phi_r[i] <= (CH + NPW)'(dg_c[i][CW-1:CL]) * (CH + NPW)'(dg_sb.np);
      end
    end
  end

  logic           s8_v_r;
  logic [PW-1:0]  s8_p_r [3];
  logic [NPW-1:0] s8_g_r;
  sb2_t           s8_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_g_r  <= s7_g_r;
      s8_sb_r <= s7_sb_r;
      for (int i = 0; i < 3; i++) begin
        s8_p_r[i] <= (PW'(s7_phi_r[i]) << CL) + PW'(s7_plo_r[i]);
      end
    end
  end

  // Rescale of each channel by the peak.
  sba_t                    sa_in;
  logic                    ds_v [3];
  logic [NPW-1:0]          ds_q [3];
  logic [$bits(sba_t)-1:0] ds0_side;
  logic [CW-1:0]           ds1_side;
  logic [CW-1:0]           ds2_side;
  sba_t                    ds_sb;

  assign sa_in.comp = s8_sb_r.comp;
  assign sa_in.np   = s8_sb_r.np;
  assign sa_in.g    = s8_g_r;
  assign sa_in.c0   = s8_sb_r.c0;

  pntg_div #(
    .NW(PW), .DW(CW), .QW(NPW), .SW($bits(sba_t))
  ) u_div_scale0 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s8_v_r), .in_num(s8_p_r[0]), .in_den(s8_sb_r.peak), .in_side(sa_in),
    .out_valid(ds_v[0]), .out_quo(ds_q[0]), .out_side(ds0_side)
  );

  pntg_div #(
    .NW(PW), .DW(CW), .QW(NPW), .SW(CW)
  ) u_div_scale1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s8_v_r), .in_num(s8_p_r[1]), .in_den(s8_sb_r.peak), .in_side(s8_sb_r.c1),
    .out_valid(ds_v[1]), .out_quo(ds_q[1]), .out_side(ds1_side)
  );

  pntg_div #(
    .NW(PW), .DW(CW), .QW(NPW), .SW(CW)
  ) u_div_scale2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s8_v_r), .in_num(s8_p_r[2]), .in_den(s8_sb_r.peak), .in_side(s8_sb_r.c2),
    .out_valid(ds_v[2]), .out_quo(ds_q[2]), .out_side(ds2_side)
  );

  assign ds_sb = sba_t'(ds0_side);

  // Blend toward the compressed peak.
  logic [NPW-1:0] gap [3];
  logic           s9_v_r;
  logic           s9_comp_r;
  logic [NPW-1:0] s9_cs_r [3];
  logic [GMW-1:0] s9_gm_r [3];
  logic [CW-1:0]  s9_c_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gap[i] = (ds_sb.np > ds_q[i]) ? ds_sb.np - ds_q[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r <= 1'b0;
    end else if (en) begin
      s9_v_r <= ds_v[0] && ds_v[1] && ds_v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_comp_r <= ds_sb.comp;
      s9_c_r[0] <= ds_sb.c0;
      s9_c_r[1] <= ds1_side;
      s9_c_r[2] <= ds2_side;
      for (int i = 0; i < 3; i++) begin
        s9_cs_r[i] <= ds_q[i];
        s9_gm_r[i] <= GMW'(gap[i]) * GMW'(ds_sb.g);
      end
    end
  end

  // Gamma address and saturation.
  logic [MXW-1:0] mixed [3];
  logic [CW-1:0]  lin [3];
  logic           s10_v_r;
  logic [AW-1:0]  s10_a_r [3];
  logic           s10_sat_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mixed[i] = MXW'(s9_cs_r[i]) + MXW'(s9_gm_r[i] >> F);
      lin[i]   = s9_comp_r ? CW'(mixed[i]) : s9_c_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r <= 1'b0;
    end else if (en) begin
      s10_v_r <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s10_sat_r[i] <= lin[i] >= ONE_C;
        s10_a_r[i]   <= AW'({lin[i][F-1:0], {AW{1'b0}}} >> F) & AMASK;
      end
    end
  end

  logic                       gm_v [3];
  logic [pntg_pkg::OUT_W-1:0] gm_byte [3];

  for (genvar i = 0; i < 3; i++) begin : g_gamma
    pntg_gamma u_gamma (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(s10_v_r), .in_a30(s10_a_r[i]), .in_sat(s10_sat_r[i]),
      .out_valid(gm_v[i]), .out_byte(gm_byte[i])
    );
  end

  assign out_valid = gm_v[0] && gm_v[1] && gm_v[2];
  assign out_red   = gm_byte[0];
  assign out_green = gm_byte[1];
  assign out_blue  = gm_byte[2];

endmodule
